/* src/bps_pkg.sv */
`timescale 1ns / 1ps

package bps_pkg;

    localparam int TIME_W    = 32;
    localparam int REQ_W     = 3;
    localparam int CNT_W     = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 40;   // time_ms + request, padded to bytes
    localparam int M_DATA_W  = 8;    // three flags, padded to a byte

    // default pattern repeat counts
    localparam int HURRY_PULSES_DEF = 3;
    localparam int DECAY_STEPS_DEF  = 7;
    localparam int LOW_CYCLES_DEF   = 80;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONCE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ODD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_EVEN = 3'd7;

    // register reset values
    localparam logic [CFG_W-1:0] SHORT_RST    = 16'd100;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd250;
    localparam logic [CFG_W-1:0] REST_RST     = 16'd50;
    localparam logic [CFG_W-1:0] INTER_RST    = 16'd100;
    localparam logic [CFG_W-1:0] WAIT_RST     = 16'd100;
    localparam logic [CFG_W-1:0] ONCE_RST     = 16'd25;
    localparam logic [CFG_W-1:0] LOW_ODD_RST  = 16'd2;
    localparam logic [CFG_W-1:0] LOW_EVEN_RST = 16'd5;

    typedef enum logic [REQ_W-1:0] {
        REQ_NONE   = 3'd0,
        REQ_SHORT  = 3'd1,
        REQ_LONG   = 3'd2,
        REQ_DOUBLE = 3'd3,
        REQ_HURRY  = 3'd4,
        REQ_DECAY  = 3'd5,
        REQ_ONCE   = 3'd6,
        REQ_LOW    = 3'd7
    } req_t;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_ON      = 7'b0000010,
        PH_DBL_ON  = 7'b0000100,
        PH_DBL_GAP = 7'b0001000,
        PH_HURRY   = 7'b0010000,
        PH_DECAY   = 7'b0100000,
        PH_LOW     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] short_ms;
        logic [CFG_W-1:0] long_ms;
        logic [CFG_W-1:0] rest_ms;
        logic [CFG_W-1:0] inter_ms;
        logic [CFG_W-1:0] wait_ms;
        logic [CFG_W-1:0] once_ms;
        logic [CFG_W-1:0] low_odd_ms;
        logic [CFG_W-1:0] low_even_ms;
    } cfg_t;

    // buzzer_on ends up in bit 0
    typedef struct packed {
        logic pending;
        logic busy_res;
        logic buzzer_on;
    } res_t;

endpackage

/* src/bps_cfg_regs.sv */
`timescale 1ns / 1ps

module bps_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bps_pkg::CFG_W-1:0]     cfg_wdata,
    output bps_pkg::cfg_t                 cfg
);
    import bps_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ms    <= SHORT_RST;
            cfg_reg.long_ms     <= LONG_RST;
            cfg_reg.rest_ms     <= REST_RST;
            cfg_reg.inter_ms    <= INTER_RST;
            cfg_reg.wait_ms     <= WAIT_RST;
            cfg_reg.once_ms     <= ONCE_RST;
            cfg_reg.low_odd_ms  <= LOW_ODD_RST;
            cfg_reg.low_even_ms <= LOW_EVEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SHORT:    cfg_reg.short_ms    <= cfg_wdata;
                CFG_LONG:     cfg_reg.long_ms     <= cfg_wdata;
                CFG_REST:     cfg_reg.rest_ms     <= cfg_wdata;
                CFG_INTER:    cfg_reg.inter_ms    <= cfg_wdata;
                CFG_WAIT:     cfg_reg.wait_ms     <= cfg_wdata;
                CFG_ONCE:     cfg_reg.once_ms     <= cfg_wdata;
                CFG_LOW_ODD:  cfg_reg.low_odd_ms  <= cfg_wdata;
                CFG_LOW_EVEN: cfg_reg.low_even_ms <= cfg_wdata;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/bps_core.sv */
`timescale 1ns / 1ps

module bps_core #(
    parameter int HURRY_PULSES = bps_pkg::HURRY_PULSES_DEF,
    parameter int DECAY_STEPS  = bps_pkg::DECAY_STEPS_DEF,
    parameter int LOW_CYCLES   = bps_pkg::LOW_CYCLES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [bps_pkg::TIME_W-1:0] time_ms,
    input  logic [bps_pkg::REQ_W-1:0]  request,
    input  bps_pkg::cfg_t              cfg,
    output bps_pkg::res_t              res
);
    import bps_pkg::*;

    localparam logic [CNT_W-1:0]  HURRY_INIT = CNT_W'(2 * HURRY_PULSES - 1);
    localparam logic [CNT_W-1:0]  DECAY_INIT = CNT_W'(2 * DECAY_STEPS - 1);
    localparam logic [CNT_W-1:0]  LOW_INIT   = CNT_W'(2 * LOW_CYCLES - 1);
    localparam logic [TIME_W-1:0] DECAY_LEN  = TIME_W'(DECAY_STEPS);

    phase_t             phase_reg, phase_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]  quiet_reg, quiet_next;
    logic [REQ_W-1:0]   pend_reg, pend_next;
    logic               pin_reg, pin_next;

    logic [REQ_W-1:0]   pend_eff;
    logic               go;
    logic               start;
    phase_t             ph_s, ph_e;
    logic [TIME_W-1:0]  len_s;
    logic [CNT_W-1:0]   cnt_s, cnt_e, cnt_dec;
    logic [TIME_W:0]    start_sum;
    logic [TIME_W-1:0]  dl_e;
    logic               early;
    logic [TIME_W-1:0]  exp_op, exp_sum;
    logic               cnt_zero;

    assign pend_eff = (request != REQ_NONE) ? request : pend_reg;
    assign go       = (time_ms >= quiet_reg);
    assign start    = go && (pend_eff != REQ_NONE) && (phase_reg == PH_IDLE);

    // first phase of the requested pattern
    always_comb
    begin
        ph_s  = PH_IDLE;
        len_s = '0;
        cnt_s = count_reg;
        unique case (req_t'(pend_eff))
            REQ_SHORT:
            begin
                ph_s  = PH_ON;
                len_s = TIME_W'(cfg.short_ms);
            end
            REQ_LONG:
            begin
                ph_s  = PH_ON;
                len_s = TIME_W'(cfg.long_ms);
            end
            REQ_DOUBLE:
            begin
                ph_s  = PH_DBL_ON;
                len_s = TIME_W'(cfg.short_ms);
            end
            REQ_HURRY:
            begin
                ph_s  = PH_HURRY;
                len_s = TIME_W'(cfg.rest_ms);
                cnt_s = HURRY_INIT;
            end
            REQ_DECAY:
            begin
                ph_s  = PH_DECAY;
                len_s = DECAY_LEN;
                cnt_s = DECAY_INIT;
            end
            REQ_ONCE:
            begin
                ph_s  = PH_ON;
                len_s = TIME_W'(cfg.once_ms);
            end
            REQ_LOW:
            begin
                ph_s  = PH_LOW;
                len_s = TIME_W'(cfg.low_odd_ms);
                cnt_s = LOW_INIT;
            end
            default:
            begin
                ph_s  = PH_IDLE;
            end
        endcase
    end

    // a fresh deadline is still ahead when the length is nonzero and did not wrap
    assign start_sum = {1'b0, time_ms} + {1'b0, len_s};
    assign ph_e      = start ? ph_s : phase_reg;
    assign cnt_e     = start ? cnt_s : count_reg;
    assign dl_e      = start ? start_sum[TIME_W-1:0] : deadline_reg;
    assign early     = start ? ((len_s != '0) && !start_sum[TIME_W])
                             : (time_ms < deadline_reg);
    assign cnt_dec   = cnt_e - CNT_W'(1);
    assign cnt_zero  = (cnt_dec == '0);

    // length added to the tick time when the current phase runs out
    always_comb
    begin
        unique case (ph_e)
            PH_ON:      exp_op = TIME_W'(cfg.wait_ms);
            PH_DBL_ON:  exp_op = TIME_W'(cfg.inter_ms);
            PH_DBL_GAP: exp_op = TIME_W'(cfg.short_ms);
            PH_HURRY:   exp_op = cnt_zero ? TIME_W'(cfg.wait_ms) : TIME_W'(cfg.rest_ms);
            PH_DECAY:   exp_op = cnt_zero ? TIME_W'(cfg.wait_ms) : TIME_W'(cnt_dec);
            PH_LOW:
            begin
                if (cnt_zero)
                    exp_op = TIME_W'(cfg.wait_ms);
                else if (cnt_dec[0])
                    exp_op = TIME_W'(cfg.low_odd_ms);
                else
                    exp_op = TIME_W'(cfg.low_even_ms);
            end
            default:    exp_op = TIME_W'(cfg.wait_ms);
        endcase
    end

    assign exp_sum = time_ms + exp_op;

    always_comb
    begin
        phase_next    = phase_reg;
        deadline_next = deadline_reg;
        count_next    = count_reg;
        quiet_next    = quiet_reg;
        pend_next     = pend_eff;
        pin_next      = pin_reg;
        if (go)
        begin
            phase_next    = ph_e;
            deadline_next = dl_e;
            count_next    = cnt_e;
            pend_next     = start ? REQ_NONE : pend_eff;
            unique case (ph_e)
                PH_ON:
                begin
                    if (early)
                        pin_next = 1'b1;
                    else
                    begin
                        phase_next = PH_IDLE;
                        pin_next   = 1'b0;
                        quiet_next = exp_sum;
                    end
                end
                PH_DBL_ON:
                begin
                    if (early)
                        pin_next = 1'b1;
                    else
                    begin
                        phase_next    = PH_DBL_GAP;
                        deadline_next = exp_sum;
                        pin_next      = 1'b0;
                    end
                end
                PH_DBL_GAP:
                begin
                    if (early)
                        pin_next = 1'b0;
                    else
                    begin
                        phase_next    = PH_ON;
                        deadline_next = exp_sum;
                        pin_next      = 1'b1;
                    end
                end
                PH_HURRY, PH_DECAY, PH_LOW:
                begin
                    if (early)
                        pin_next = cnt_e[0];
                    else
                    begin
                        count_next = cnt_dec;
                        if (cnt_zero)
                        begin
                            phase_next = PH_IDLE;
                            pin_next   = 1'b0;
                            quiet_next = exp_sum;
                        end
                        else
                            deadline_next = exp_sum;
                    end
                end
                default:
                begin
                    phase_next = ph_e;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            deadline_reg <= '0;
            count_reg    <= '0;
            quiet_reg    <= '0;
            pend_reg     <= REQ_NONE;
            pin_reg      <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            deadline_reg <= deadline_next;
            count_reg    <= count_next;
            quiet_reg    <= quiet_next;
            pend_reg     <= pend_next;
            pin_reg      <= pin_next;
        end
    end

    assign res.buzzer_on = pin_next;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.pending   = (pend_next != REQ_NONE);

`ifndef ASSERT_OFF
    a_quiet_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !go |=> phase_reg == $past(phase_reg))
        else $error("phase moved during quiet gap");

    a_pin_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pin_reg |-> phase_reg != PH_IDLE)
        else $error("buzzer driven while idle");

    a_pulse_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HURRY || phase_reg == PH_DECAY || phase_reg == PH_LOW)
        |-> count_reg != '0)
        else $error("pulse phase with zero count");

    // a zero-length first phase may end on the start tick, so only the latch is checked
    a_start_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        advance && start |=> pend_reg == REQ_NONE)
        else $error("pattern start did not consume request");
`endif

endmodule

/* src/buzzer_pattern_sequencer_top.sv */
`timescale 1ns / 1ps

// buzzer pattern sequencer: every s_axis transaction is one millisecond tick
// (time stamp plus optional pattern request) and produces exactly one
// m_axis transaction with the held buzzer pin level, a busy flag and a
// pending-request flag. a nonzero request replaces the latched one; an idle
// sequencer starts it once the post-pattern quiet gap has passed. throughput
// is one tick per clock while m_axis_tready keeps the result register
// draining: the tick sits in an input register, one pass of compare/add logic
// updates the sequencer state and fills the result register, and the input
// register refills while a result waits. phase lengths other than the decay
// steps come from eight 16-bit registers written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while no tick is in flight, which the block does
// not enforce; indexes are short, long, rest, inter, wait, once, low_odd, low_even
module buzzer_pattern_sequencer_top #(
    parameter int HURRY_PULSES = bps_pkg::HURRY_PULSES_DEF,
    parameter int DECAY_STEPS  = bps_pkg::DECAY_STEPS_DEF,
    parameter int LOW_CYCLES   = bps_pkg::LOW_CYCLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // tick input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bps_pkg::S_DATA_W-1:0]  s_axis_tdata,  // time_ms[31:0], request[34:32]
    // result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bps_pkg::M_DATA_W-1:0]  m_axis_tdata,  // buzzer_on[0], busy_res[1], pending[2]
    // configuration writes
    input  logic                          cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bps_pkg::CFG_W-1:0]     cfg_wdata
);
    import bps_pkg::*;

    cfg_t               cfg;
    res_t               res;

    // input stage
    logic               in_valid_reg;
    logic [TIME_W-1:0]  in_time_reg;
    logic [REQ_W-1:0]   in_req_reg;

    // result stage
    logic               out_valid_reg;
    res_t               out_res_reg;

    logic               advance;
    logic               s_take;

    // tick moves into the result register when that slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_time_reg <= s_axis_tdata[TIME_W-1:0];
            in_req_reg  <= s_axis_tdata[TIME_W +: REQ_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    bps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bps_core #(
        .HURRY_PULSES (HURRY_PULSES),
        .DECAY_STEPS  (DECAY_STEPS),
        .LOW_CYCLES   (LOW_CYCLES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .time_ms (in_time_reg),
        .request (in_req_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - $bits(res_t)){1'b0}}, out_res_reg};

endmodule
